[src/complex_arith_unit_assert.svh]
`ifndef COMPLEX_ARITH_UNIT_ASSERT_SVH
`define COMPLEX_ARITH_UNIT_ASSERT_SVH

// Checks a consequent in the same cycle as its antecedent.
`define CAU_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks a consequent in the cycle after its antecedent.
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[src/cau_pkg.sv]
`default_nettype none
package cau_pkg;
  localparam int DW = 16;
  localparam int FB = 8;
  localparam int QB = DW + 1;
  localparam int NCELL = QB;
  localparam int PW = 2 * DW;
  localparam int VW = PW + 2;
  localparam int IW = $clog2(NCELL);

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_t;
  typedef enum logic [1:0] {ST_OK, ST_SAT, ST_DZ, ST_RSVD} status_t;

  typedef struct packed {
    logic vld;
    op_t op;
    logic dz;
    logic signed [VW-1:0] v_re;
    logic signed [VW-1:0] v_im;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
    logic [PW-1:0] den;
    logic [PW-1:0] rem_re;
    logic [PW-1:0] rem_im;
    logic [QB-1:0] q_re;
    logic [QB-1:0] q_im;
  } cell_t;
endpackage
`default_nettype wire

[src/cau_if.sv]
`default_nettype none
interface cau_req_if;
  logic valid;
  logic ready;
  logic [1:0] req_type;
  logic signed [15:0] a_re;
  logic signed [15:0] a_im;
  logic signed [15:0] b_re;
  logic signed [15:0] b_im;
  modport source(output valid, req_type, a_re, a_im, b_re, b_im, input ready);
  modport sink(input valid, req_type, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if;
  logic valid;
  logic ready;
  logic signed [15:0] res_re;
  logic signed [15:0] res_im;
  logic [1:0] status;
  modport source(output valid, res_re, res_im, status, input ready);
  modport sink(input valid, res_re, res_im, status, output ready);
endinterface
`default_nettype wire

[src/cau_cell.sv]
`default_nettype none
module cau_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic [cau_pkg::IW-1:0] idx,
  input  wire cau_pkg::cell_t     d,
  output cau_pkg::cell_t          q
);
  import cau_pkg::*;

  logic [IW-1:0] j;
  logic nb_re, nb_im;
  logic [PW:0] r2_re, r2_im;
  logic ge_re, ge_im;
  cell_t q_next;

  always_comb begin
    j = IW'(QB - 1) - idx;
    nb_re = 1'b0;
    nb_im = 1'b0;
    if (j >= IW'(FB)) begin
      nb_re = d.v_re[j - IW'(FB)];
      nb_im = d.v_im[j - IW'(FB)];
    end
    r2_re = {d.rem_re, nb_re};
    r2_im = {d.rem_im, nb_im};
    ge_re = r2_re >= {1'b0, d.den};
    ge_im = r2_im >= {1'b0, d.den};
    q_next = d;
    q_next.rem_re = ge_re ? PW'(r2_re - {1'b0, d.den}) : PW'(r2_re);
    q_next.rem_im = ge_im ? PW'(r2_im - {1'b0, d.den}) : PW'(r2_im);
    q_next.q_re = {d.q_re[QB-2:0], ge_re};
    q_next.q_im = {d.q_im[QB-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.vld <= 1'b0;
    end else if (en) begin
      q <= q_next;
    end
  end
endmodule
`default_nettype wire

[src/complex_arith_unit.sv]
// Complex arithmetic unit, signed Q8.8 operands and results.
// Request channel "in" carries req_type (add, subtract, multiply, divide)
// and the complex operands a and b; response channel "out" returns res_re,
// res_im and status (ok, saturated, divide by zero), one per request.
// A transaction completes on a clock edge where valid and ready are high.
// The pipeline holds two front stages (products, then sums and |b|^2),
// a row of 17 identical divider cells that each resolve one quotient bit,
// and an output register.
// One request is taken every cycle while the receiver does not stall, any operation mix.
// When the receiver stalls, the whole pipeline holds and in.ready falls
// with the output register still full; it rises again as soon as the
// waiting result is taken.
// A synchronous reset empties the pipeline; the unit keeps no other state.
// Division truncates toward zero; multiply rounds toward minus infinity.
// Out-of-range components clamp and report saturation.
`default_nettype none
`include "complex_arith_unit_assert.svh"
module complex_arith_unit (
  input wire logic clk,
  input wire logic rst,
  cau_req_if.sink  in,
  cau_rsp_if.source out
);
  import cau_pkg::*;

  localparam logic signed [VW-1:0] POS_LIM = VW'((1 <<< (DW - 1)) - 1);
  localparam logic signed [VW-1:0] NEG_LIM = -VW'(1 <<< (DW - 1));

  logic en;
  logic s0_vld;
  op_t s0_op;
  logic signed [DW:0] s0_sre, s0_sim;
  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir;
  logic [PW-1:0] b2r, b2i;
  cell_t s1, s1_next;
  cell_t c [NCELL+1];
  logic signed [VW-1:0] t_re, t_im, val_re, val_im;
  logic [PW-1:0] den, mag_re, mag_im;
  logic signed [DW-1:0] o_re, o_im;
  status_t o_st;
  logic sat_re, sat_im;

  assign en = !out.valid || out.ready;
  assign in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (en) begin
      s0_vld <= in.valid;
      s0_op <= op_t'(in.req_type);
      if (in.req_type == OP_SUB) begin
        s0_sre <= (DW+1)'(in.a_re) - (DW+1)'(in.b_re);
        s0_sim <= (DW+1)'(in.a_im) - (DW+1)'(in.b_im);
      end else begin
        s0_sre <= (DW+1)'(in.a_re) + (DW+1)'(in.b_re);
        s0_sim <= (DW+1)'(in.a_im) + (DW+1)'(in.b_im);
      end
      p_rr <= in.a_re * in.b_re;
      p_ii <= in.a_im * in.b_im;
      p_ri <= in.a_re * in.b_im;
      p_ir <= in.a_im * in.b_re;
      b2r <= PW'(in.b_re * in.b_re);
      b2i <= PW'(in.b_im * in.b_im);
    end
  end

  always_comb begin
    t_re = VW'(p_rr) + VW'(p_ii);
    t_im = VW'(p_ir) - VW'(p_ri);
    den = b2r + b2i;
    mag_re = t_re[VW-1] ? PW'(-t_re) : PW'(t_re);
    mag_im = t_im[VW-1] ? PW'(-t_im) : PW'(t_im);
    s1_next = '0;
    s1_next.vld = s0_vld;
    s1_next.op = s0_op;
    s1_next.den = den;
    unique case (s0_op) inside
      OP_ADD, OP_SUB: begin
        s1_next.v_re = VW'(s0_sre);
        s1_next.v_im = VW'(s0_sim);
      end
      OP_MUL: begin
        s1_next.v_re = (VW'(p_rr) - VW'(p_ii)) >>> FB;
        s1_next.v_im = (VW'(p_ri) + VW'(p_ir)) >>> FB;
      end
      default: begin
        s1_next.dz = den == '0;
        s1_next.v_re = VW'(mag_re);
        s1_next.v_im = VW'(mag_im);
        s1_next.neg_re = t_re[VW-1];
        s1_next.neg_im = t_im[VW-1];
        s1_next.rem_re = mag_re >> (QB - FB);
        s1_next.rem_im = mag_im >> (QB - FB);
        s1_next.ovf_re = (mag_re >> (QB - FB)) >= den;
        s1_next.ovf_im = (mag_im >> (QB - FB)) >= den;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.vld <= 1'b0;
    end else if (en) begin
      s1 <= s1_next;
    end
  end

  assign c[0] = s1;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    cau_cell u_cell (
      .clk(clk),
      .rst(rst),
      .en(en),
      .idx(IW'(k)),
      .d(c[k]),
      .q(c[k+1])
    );
  end

  always_comb begin
    val_re = c[NCELL].v_re;
    val_im = c[NCELL].v_im;
    if (c[NCELL].op == OP_DIV) begin
      val_re = c[NCELL].neg_re ? -VW'(c[NCELL].q_re) : VW'(c[NCELL].q_re);
      val_im = c[NCELL].neg_im ? -VW'(c[NCELL].q_im) : VW'(c[NCELL].q_im);
      if (c[NCELL].ovf_re) val_re = c[NCELL].neg_re ? NEG_LIM - 1 : POS_LIM + 1;
      if (c[NCELL].ovf_im) val_im = c[NCELL].neg_im ? NEG_LIM - 1 : POS_LIM + 1;
    end
    sat_re = val_re > POS_LIM || val_re < NEG_LIM;
    sat_im = val_im > POS_LIM || val_im < NEG_LIM;
    o_re = val_re > POS_LIM ? DW'(POS_LIM) : val_re < NEG_LIM ? DW'(NEG_LIM) : DW'(val_re);
    o_im = val_im > POS_LIM ? DW'(POS_LIM) : val_im < NEG_LIM ? DW'(NEG_LIM) : DW'(val_im);
    o_st = (sat_re || sat_im) ? ST_SAT : ST_OK;
    if (c[NCELL].op == OP_DIV && c[NCELL].dz) begin
      o_re = '0;
      o_im = '0;
      o_st = ST_DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (en) begin
      out.valid <= c[NCELL].vld;
      out.res_re <= o_re;
      out.res_im <= o_im;
      out.status <= o_st;
    end
  end

  `CAU_ASSERT_NOW(a_dz_zero, clk, rst, out.valid && out.status == ST_DZ,
    out.res_re == '0 && out.res_im == '0)
  `CAU_ASSERT_NOW(a_status_code, clk, rst, out.valid,
    out.status == ST_OK || out.status == ST_SAT || out.status == ST_DZ)
  `CAU_ASSERT_NEXT(a_stall_hold, clk, rst, out.valid && !out.ready,
    out.valid && $stable(c[NCELL].v_re) && $stable(s1.v_re))
endmodule
`default_nettype wire
